// ===== design/trns_pkg.sv =====
// Shared types and constants for the tracker row note sequencer.
// Used by trns_front, trns_queue, trns_back and tracker_row_note_sequencer_top.
package trns_pkg;

  localparam int COLUMNS = 16;
  localparam int CNT_W = $clog2(COLUMNS + 1);
  localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] STATUS_NOTE_ON = 8'h90;
  localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
  localparam logic [6:0] VELOCITY_RESET = 7'h40;
  localparam logic [6:0] VELOCITY_OFF = 7'h00;

  localparam logic [1:0] CMD_NOTE = 2'd0;
  localparam logic [1:0] CMD_HOLD = 2'd1;
  localparam logic [1:0] CMD_REST = 2'd2;
  localparam logic [1:0] CMD_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] pitch;
    logic       row_end;
  } in_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] note_number;
    logic [6:0] velocity;
    logic       last;
  } out_t;

  // Classified cell as handed from the front end to the back end.
  typedef struct packed {
    logic               is_cell;   // note or rest on a column inside the row
    logic               is_note;
    logic [COL_W-1:0]   col;
    logic [6:0]         pitch;
    logic [COLUMNS-1:0] end_mask;  // columns whose sounding notes get ended
  } op_t;

endpackage

// ===== design/trns_front.sv =====
// Front end: accepts cells, tracks the column and classifies each cell into an op.
// Depends on trns_pkg.
module trns_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  trns_pkg::in_t   in_data,
  output logic            op_valid,
  input  logic            op_ready,
  output trns_pkg::op_t   op_data
);

  logic [trns_pkg::CNT_W-1:0] column;
  logic [trns_pkg::CNT_W-1:0] column_next;
  logic [trns_pkg::CNT_W-1:0] col_after;
  logic                       in_range;
  logic                       take;

  assign in_ready = op_ready;
  assign op_valid = in_valid;
  assign take = in_valid && op_ready;

  always_comb begin
    in_range = column < trns_pkg::CNT_W'(trns_pkg::COLUMNS);
    col_after = in_range ? column + trns_pkg::CNT_W'(1) : column;
    op_data.pitch = in_data.pitch;
    op_data.col = column[trns_pkg::COL_W-1:0];
    op_data.is_note = in_data.cmd == trns_pkg::CMD_NOTE;
    if (in_data.cmd == trns_pkg::CMD_EMPTY) begin
      op_data.is_cell = 1'b0;
      op_data.end_mask = '1;
      column_next = '0;
    end else begin
      op_data.is_cell = in_range && (in_data.cmd != trns_pkg::CMD_HOLD);
      if (in_data.row_end) begin
        // end everything past the row's length
        op_data.end_mask = {trns_pkg::COLUMNS{1'b1}} << col_after;
        column_next = '0;
      end else begin
        op_data.end_mask = '0;
        column_next = col_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
    end else if (take) begin
      column <= column_next;
    end
  end

endmodule

// ===== design/trns_queue.sv =====
// Short queue of classified ops between front and back ends.
// Depends on trns_pkg.
module trns_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  trns_pkg::op_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output trns_pkg::op_t rd_data
);

  trns_pkg::op_t               mem [trns_pkg::QUEUE_DEPTH];
  logic [trns_pkg::QPTR_W-1:0] wr_ptr;
  logic [trns_pkg::QPTR_W-1:0] rd_ptr;
  logic [trns_pkg::QCNT_W-1:0] count;
  logic                        push;
  logic                        pop;

  assign wr_ready = count != trns_pkg::QCNT_W'(trns_pkg::QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign rd_data = mem[rd_ptr];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == trns_pkg::QPTR_W'(trns_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + trns_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == trns_pkg::QPTR_W'(trns_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + trns_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + trns_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - trns_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

// ===== design/trns_back.sv =====
// Back end: holds per-column note state and emits one MIDI message per cycle while the receiver is ready.
// Depends on trns_pkg.
module trns_back (
  input  logic          clk,
  input  logic          rst,
  input  logic [6:0]    on_velocity,
  input  logic          op_valid,
  output logic          op_ready,
  input  trns_pkg::op_t op_data,
  output logic          out_valid,
  input  logic          out_ready,
  output trns_pkg::out_t out_data
);

  logic [trns_pkg::COLUMNS-1:0] sounding;
  logic [6:0]                   held_pitch [trns_pkg::COLUMNS];
  logic                         busy;
  logic                         cell_pend;
  trns_pkg::op_t                op;

  logic [trns_pkg::COLUMNS-1:0] hits;
  logic [trns_pkg::COLUMNS-1:0] low;
  logic [6:0]                   sweep_pitch;
  logic                         cell_off;
  logic                         emit;
  logic                         out_free;
  logic                         step;
  trns_pkg::out_t               msg;

  assign op_ready = !busy;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    hits = op.end_mask & sounding;
    low = hits & (~hits + trns_pkg::COLUMNS'(1));
    sweep_pitch = '0;
    for (int i = 0; i < trns_pkg::COLUMNS; i++) begin
      sweep_pitch = sweep_pitch | (held_pitch[i] & {7{low[i]}});
    end
    cell_off = cell_pend && sounding[op.col];
    emit = 1'b0;
    msg.status_byte = trns_pkg::STATUS_NOTE_OFF;
    msg.note_number = sweep_pitch;
    msg.velocity = trns_pkg::VELOCITY_OFF;
    msg.last = 1'b0;
    if (cell_pend) begin
      if (cell_off) begin
        emit = 1'b1;
        msg.note_number = held_pitch[op.col];
        msg.last = !op.is_note && !(|hits);
      end else if (op.is_note) begin
        emit = 1'b1;
        msg.status_byte = trns_pkg::STATUS_NOTE_ON;
        msg.note_number = op.pitch;
        msg.velocity = on_velocity;
        msg.last = !(|hits);
      end
    end else if (|hits) begin
      emit = 1'b1;
      msg.last = !(|(hits & ~low));
    end
    step = busy && (!emit || out_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cell_pend <= 1'b0;
      sounding <= '0;
    end else if (!busy) begin
      if (op_valid) begin
        busy <= 1'b1;
        cell_pend <= op_data.is_cell;
      end
    end else if (step) begin
      if (cell_pend) begin
        if (cell_off) begin
          sounding[op.col] <= 1'b0;
        end else begin
          cell_pend <= 1'b0;
          if (op.is_note) begin
            sounding[op.col] <= 1'b1;
          end
        end
      end else if (|hits) begin
        sounding <= sounding & ~low;
      end else begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && op_valid) begin
      op <= op_data;
    end
    if (step && cell_pend && !cell_off && op.is_note) begin
      held_pitch[op.col] <= op.pitch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= busy && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && busy && emit) begin
      out_data <= msg;
    end
  end

endmodule

// ===== design/tracker_row_note_sequencer_top.sv =====
// Tracker row note sequencer: turns pattern cells into MIDI note-off/note-on messages.
// A cell is classified combinationally and written into the queue when accepted; the
// back end then loads it, emits its messages one by one, spends an extra step on a rest
// cell and a final step on finishing. A note cell whose row end ends every other column
// gives the most messages. The back end's output register passes one message per cycle
// while the receiver is ready; a two-entry queue lets cells arrive while earlier ones
// are still being worked off. Depends on trns_pkg and submodules.
module tracker_row_note_sequencer_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  trns_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output trns_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [6:0]     cfg_data
);

  logic [6:0]    on_velocity;
  logic          f_valid;
  logic          f_ready;
  trns_pkg::op_t f_op;
  logic          q_valid;
  logic          q_ready;
  trns_pkg::op_t q_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      on_velocity <= trns_pkg::VELOCITY_RESET;
    end else if (cfg_we) begin
      on_velocity <= cfg_data;
    end
  end

  trns_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .op_valid (f_valid),
    .op_ready (f_ready),
    .op_data  (f_op)
  );

  trns_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_op),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_op)
  );

  trns_back u_back (
    .clk         (clk),
    .rst         (rst),
    .on_velocity (on_velocity),
    .op_valid    (q_valid),
    .op_ready    (q_ready),
    .op_data     (q_op),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// ===== sim/midi_msg_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the tracker row note sequencer: watches both channels, predicts MIDI messages.
// Depends on trns_pkg for the payload types, cell codes and status bytes.
module midi_msg_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_ready,
  input  trns_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  trns_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [6:0]     cfg_data,
  output int             outstanding,
  output int             errors
);

  localparam int EXP_DEPTH = 4096;
  localparam int EXP_IDX_W = 12;

  // Shadow of the block's column state and velocity register
  bit         sounding_col [trns_pkg::COLUMNS];
  logic [6:0] held_note [trns_pkg::COLUMNS];
  int         next_col;
  logic [6:0] on_vel;

  // Expected messages in order; the indexes only grow, their low bits address the ring
  trns_pkg::out_t exp_ring [EXP_DEPTH];
  int             wr_idx;
  int             rd_idx;
  trns_pkg::out_t seen;
  trns_pkg::out_t want;

  task automatic report_mismatch(input string what);
    $display("%0t ns: checker: %s", $time, what);
    errors++;
  endtask

  function automatic void add_msg(input trns_pkg::out_t m);
    exp_ring[wr_idx[EXP_IDX_W-1:0]] = m;
    wr_idx++;
  endfunction

  function automatic void end_column(input int c);
    trns_pkg::out_t m;
    if (sounding_col[c]) begin
      m.status_byte = trns_pkg::STATUS_NOTE_OFF;
      m.note_number = held_note[c];
      m.velocity    = trns_pkg::VELOCITY_OFF;
      m.last        = 1'b0;
      add_msg(m);
      sounding_col[c] = 1'b0;
    end
  endfunction

  // Work out the messages of one cell, in order, and queue them
  function automatic void predict_cell_msgs(input trns_pkg::in_t txn);
    trns_pkg::out_t m;
    int             c;
    int             first;
    int             last_idx;
    first = wr_idx;
    if (txn.cmd == trns_pkg::CMD_EMPTY) begin
      for (c = 0; c < trns_pkg::COLUMNS; c++) end_column(c);
      next_col = 0;
    end else begin
      if (next_col < trns_pkg::COLUMNS) begin
        c = next_col;
        if (txn.cmd == trns_pkg::CMD_NOTE) begin
          end_column(c);
          m.status_byte = trns_pkg::STATUS_NOTE_ON;
          m.note_number = txn.pitch;
          m.velocity    = on_vel;
          m.last        = 1'b0;
          add_msg(m);
          sounding_col[c] = 1'b1;
          held_note[c] = txn.pitch;
        end else if (txn.cmd == trns_pkg::CMD_REST) begin
          end_column(c);
        end
        next_col = c + 1;
      end
      if (txn.row_end) begin
        for (c = next_col; c < trns_pkg::COLUMNS; c++) end_column(c);
        next_col = 0;
      end
    end
    if (wr_idx != first) begin
      last_idx = wr_idx - 1;
      exp_ring[last_idx[EXP_IDX_W-1:0]].last = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (sounding_col[i]) begin
        sounding_col[i] = 1'b0;
        held_note[i] = '0;
      end
      next_col = 0;
      on_vel = trns_pkg::VELOCITY_RESET;
      wr_idx = 0;
      rd_idx = 0;
      errors = 0;
    end else begin
      // Check the output transaction before queuing anything from this edge's input
      if (out_valid && out_ready) begin
        seen = out_data;
        if (wr_idx == rd_idx) begin
          report_mismatch($sformatf("unexpected message %h", seen));
        end else begin
          want = exp_ring[rd_idx[EXP_IDX_W-1:0]];
          rd_idx++;
          if (seen.status_byte !== want.status_byte)
            report_mismatch($sformatf("status_byte %h, want %h", seen.status_byte,
                                      want.status_byte));
          if (seen.note_number !== want.note_number)
            report_mismatch($sformatf("note_number %0d, want %0d", seen.note_number,
                                      want.note_number));
          if (seen.velocity !== want.velocity)
            report_mismatch($sformatf("velocity %0d, want %0d", seen.velocity,
                                      want.velocity));
          if (seen.last !== want.last)
            report_mismatch($sformatf("last %b, want %b", seen.last, want.last));
        end
      end
      if (cfg_we) on_vel = cfg_data;
      if (in_valid && in_ready) predict_cell_msgs(in_data);
    end
    outstanding <= wr_idx - rd_idx;
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the tracker row note sequencer testbench: clock, reset, cell stimulus and verdict.
// Depends on trns_pkg, tracker_row_note_sequencer_top and midi_msg_checker.
module tb_top;

  localparam int SETTLE_CYCLES = 40;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_ready;
  trns_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  trns_pkg::out_t out_data;
  logic           cfg_we = 1'b0;
  logic [6:0]     cfg_data = '0;

  int outstanding;
  int errors;
  int burst_left = 0;
  int stall_left = 0;
  int pick;

  always #4 clk = ~clk;

  tracker_row_note_sequencer_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  midi_msg_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .errors      (errors)
  );

  // Receiver: runs of ready, short stalls and occasional long stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        out_ready <= 1'b1;
        stall_left <= $urandom_range(1, 40);
      end else if (pick < 8) begin
        out_ready <= 1'b0;
        stall_left <= $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b0;
        stall_left <= $urandom_range(8, 20);
      end
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // Offer one cell and hold it until the transaction completes
  task automatic send_cell(input logic [1:0] cmd, input logic [6:0] pitch, input logic row_end);
    trns_pkg::in_t txn;
    int            gap;
    txn.cmd = cmd;
    txn.pitch = pitch;
    txn.row_end = row_end;
    gap = 0;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
      burst_left = $urandom_range(1, 12);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= txn;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // Drop valid, wait for every expected message, then let the back end go quiet
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_velocity(input logic [6:0] vel);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= vel;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [1:0] random_cmd;
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return trns_pkg::CMD_NOTE;
    else if (r < 7) return trns_pkg::CMD_HOLD;
    else if (r < 9) return trns_pkg::CMD_REST;
    return trns_pkg::CMD_EMPTY;
  endfunction

  // Mostly whole rows with random content, some stray cells and empty-row markers
  task automatic play_rows(input int n_cells);
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < n_cells) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        send_cell(trns_pkg::CMD_EMPTY, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
        sent++;
      end else if (r == 1) begin
        send_cell(random_cmd(), 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 19) : $urandom_range(1, 16);
        for (int i = 0; i < len; i++)
          send_cell(random_cmd(), 7'($urandom_range(0, 127)), 1'(i == len - 1));
        sent += len;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Row with note extremes, hold and rest on silent columns, then a row end
    send_cell(trns_pkg::CMD_NOTE, 7'd0, 1'b0);
    send_cell(trns_pkg::CMD_NOTE, 7'd127, 1'b0);
    send_cell(trns_pkg::CMD_HOLD, 7'd5, 1'b0);
    send_cell(trns_pkg::CMD_REST, 7'd9, 1'b0);
    send_cell(trns_pkg::CMD_NOTE, 7'd85, 1'b1);
    // Retrigger, rest on a sounding column, short row ends the sounding column beyond it
    send_cell(trns_pkg::CMD_NOTE, 7'd42, 1'b0);
    send_cell(trns_pkg::CMD_REST, 7'd0, 1'b0);
    send_cell(trns_pkg::CMD_HOLD, 7'd127, 1'b1);
    // Fill every column, then cells past the column count
    for (int i = 0; i < trns_pkg::COLUMNS; i++)
      send_cell(trns_pkg::CMD_NOTE, 7'(i * 8 + 7), 1'b0);
    send_cell(trns_pkg::CMD_NOTE, 7'd100, 1'b0);
    send_cell(trns_pkg::CMD_REST, 7'd1, 1'b1);
    // Note with row end on column 0: retrigger plus every other column ended
    send_cell(trns_pkg::CMD_NOTE, 7'd64, 1'b1);
    // Empty row with its other fields set
    send_cell(trns_pkg::CMD_EMPTY, 7'd127, 1'b1);

    write_velocity(7'd0);
    play_rows(30);
    write_velocity(7'd127);
    play_rows(30);
    write_velocity(7'($urandom_range(2, 126)));
    play_rows(30);
    write_velocity(7'd1);
    play_rows(20);
    drain();

    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
